[hw/rtl/touch_point_mapper_core_assert.svh]
// Assertion macros shared by the checker of the touch point mapper.
`ifndef TOUCH_POINT_MAPPER_CORE_ASSERT_SVH
`define TOUCH_POINT_MAPPER_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define TPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define TPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define TPM_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tpm_pkg.sv]
// Package with the types and constants of the touch point mapper.
`timescale 1ns / 1ps

package tpm_pkg;

  localparam int COEF_W = 32;
  localparam int RAW_W  = 12;
  localparam int PRES_W = 16;
  localparam int POS_W  = 9;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_AX     = 3'd0,
    REG_COEF_BX     = 3'd1,
    REG_COEF_CX     = 3'd2,
    REG_COEF_AY     = 3'd3,
    REG_COEF_BY     = 3'd4,
    REG_COEF_CY     = 3'd5,
    REG_ROTATION    = 3'd6,
    REG_SOURCE_MODE = 3'd7
  } tpm_reg_idx_t;

  typedef enum logic [1:0] {
    ROT_QUARTER  = 2'd0,
    ROT_IDENTITY = 2'd1,
    ROT_THREE_Q  = 2'd2,
    ROT_HALF     = 2'd3
  } tpm_rot_t;

  typedef enum logic [1:0] {
    MODE_RES_UNCAL = 2'd0,
    MODE_RES_CAL   = 2'd1,
    MODE_CAP       = 2'd2,
    MODE_UNUSED    = 2'd3
  } tpm_mode_t;

  typedef struct packed {
    logic              down;
    logic [RAW_W-1:0]  x;
    logic [RAW_W-1:0]  y;
    logic [PRES_W-1:0] pressure;
  } tpm_sample_t;

endpackage

[hw/rtl/tpm_affine.sv]
// One axis of the calibrated affine map: two products, offset, rounding and clamp.
`timescale 1ns / 1ps

module tpm_affine #(
  parameter int FRAC_BITS = 16,
  parameter int LIMIT     = 319,
  parameter int DIM_W     = 9
) (
  input  logic signed [tpm_pkg::COEF_W-1:0] coef_a,
  input  logic signed [tpm_pkg::COEF_W-1:0] coef_b,
  input  logic signed [tpm_pkg::COEF_W-1:0] coef_c,
  input  logic        [tpm_pkg::RAW_W-1:0]  raw_x,
  input  logic        [tpm_pkg::RAW_W-1:0]  raw_y,
  output logic        [DIM_W-1:0]           coord
);
  import tpm_pkg::*;

  localparam int PROD_W = COEF_W + RAW_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic [SUM_W-1:0] HALF  = {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [SUM_W-1:0] LIM_X = SUM_W'(LIMIT);

  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_b;
  logic signed [SUM_W-1:0]  sum;
  logic        [SUM_W-1:0]  rnd;
  logic        [SUM_W-1:0]  shifted;

  assign prod_a = coef_a * $signed({1'b0, raw_x});
  assign prod_b = coef_b * $signed({1'b0, raw_y});
  assign sum    = SUM_W'(prod_a) + SUM_W'(prod_b) + SUM_W'(coef_c);

  // A negative sum rounds to zero or below, so the clamp takes it to zero
  // and only the non-negative rounding needs to be built.
  assign rnd     = unsigned'(sum) + HALF;
  assign shifted = rnd >> FRAC_BITS;

  always_comb begin
    if (sum[SUM_W-1]) begin
      coord = '0;
    end else if (shifted > LIM_X) begin
      coord = DIM_W'(LIMIT);
    end else begin
      coord = shifted[DIM_W-1:0];
    end
  end

endmodule

[hw/rtl/tpm_orient.sv]
// Display rotation of a clamped landscape point into screen coordinates.
`timescale 1ns / 1ps

module tpm_orient #(
  parameter int SCREEN_W = 320,
  parameter int SCREEN_H = 240,
  parameter int DIM_W    = 9
) (
  input  logic [DIM_W-1:0]          lx,
  input  logic [DIM_W-1:0]          ly,
  input  tpm_pkg::tpm_rot_t         rotation,
  output logic [tpm_pkg::POS_W-1:0] pos_x,
  output logic [tpm_pkg::POS_W-1:0] pos_y
);
  import tpm_pkg::*;

  logic [DIM_W-1:0]       px;
  logic [DIM_W-1:0]       py;
  logic [DIM_W+POS_W-1:0] px_ext;
  logic [DIM_W+POS_W-1:0] py_ext;

  always_comb begin
    case (rotation)
      ROT_QUARTER: begin
        px = DIM_W'(SCREEN_H - 1) - ly;
        py = lx;
      end
      ROT_THREE_Q: begin
        px = ly;
        py = DIM_W'(SCREEN_W - 1) - lx;
      end
      ROT_HALF: begin
        px = DIM_W'(SCREEN_W - 1) - lx;
        py = DIM_W'(SCREEN_H - 1) - ly;
      end
      default: begin
        px = lx;
        py = ly;
      end
    endcase
  end

  // The result ports keep only the low bits, whatever the screen size.
  assign px_ext = {{POS_W{1'b0}}, px};
  assign py_ext = {{POS_W{1'b0}}, py};
  assign pos_x  = px_ext[POS_W-1:0];
  assign pos_y  = py_ext[POS_W-1:0];

endmodule

[hw/rtl/touch_point_mapper_core.sv]
// Touch point mapper: sample register, mapping logic, state and result register.
//
// Usage: raw touch samples enter on the in_ channel (valid/stall) and one
// mapped result leaves on the out_ channel for every sample transfer.
// Coefficients, rotation and source mode are written on the cfg_ port;
// the user must write them only while the block is idle, which the block
// itself does not enforce; there is no read-back. A sample that is taken
// is held in the sample register and mapped there, and its result is then
// loaded into the result register, which drives out_valid; a stalled result
// holds the next sample in the sample register. Throughput is one sample per
// cycle while the receiver does not stall; the single pass through the two
// affine units and the clamp sets that figure.
// The block keeps the last press state and point, so results leave in the
// order of the samples and each one depends on the one before.
// Reset (rst_n low, synchronous) empties both registers, clears the press
// state and held point, zeroes the coefficients, selects the uncalibrated
// resistive mode and the identity landscape rotation.
// When the receiver stalls, the result is held unchanged; one more sample
// is taken into the sample register, after which in_stall is raised.
`timescale 1ns / 1ps

module touch_point_mapper_core #(
  parameter int SCREEN_W  = 320,
  parameter int SCREEN_H  = 240,
  parameter int NATIVE_W  = 240,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpm_pkg::COEF_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_raw_down,
  input  logic [tpm_pkg::RAW_W-1:0]         in_raw_x,
  input  logic [tpm_pkg::RAW_W-1:0]         in_raw_y,
  input  logic [tpm_pkg::PRES_W-1:0]        in_raw_pressure,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_pressed,
  output logic [tpm_pkg::POS_W-1:0]         out_pos_x,
  output logic [tpm_pkg::POS_W-1:0]         out_pos_y,
  output logic [tpm_pkg::PRES_W-1:0]        out_pressure_out,
  output logic                              out_just_pressed,
  output logic                              out_just_released
);
  import tpm_pkg::*;

  localparam int DIM_W = $clog2(SCREEN_W > SCREEN_H ? SCREEN_W : SCREEN_H);
  localparam int CAP_W = RAW_W + 2;

  // Configuration registers.
  logic signed [COEF_W-1:0] coef_ax_r, coef_bx_r, coef_cx_r;
  logic signed [COEF_W-1:0] coef_ay_r, coef_by_r, coef_cy_r;
  tpm_rot_t                 rotation_r;
  tpm_mode_t                mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_ax_r  <= '0;
      coef_bx_r  <= '0;
      coef_cx_r  <= '0;
      coef_ay_r  <= '0;
      coef_by_r  <= '0;
      coef_cy_r  <= '0;
      rotation_r <= ROT_IDENTITY;
      mode_r     <= MODE_RES_UNCAL;
    end else if (cfg_we) begin
      case (tpm_reg_idx_t'(cfg_index))
        REG_COEF_AX:     coef_ax_r  <= cfg_data;
        REG_COEF_BX:     coef_bx_r  <= cfg_data;
        REG_COEF_CX:     coef_cx_r  <= cfg_data;
        REG_COEF_AY:     coef_ay_r  <= cfg_data;
        REG_COEF_BY:     coef_by_r  <= cfg_data;
        REG_COEF_CY:     coef_cy_r  <= cfg_data;
        REG_ROTATION:    rotation_r <= tpm_rot_t'(cfg_data[1:0]);
        REG_SOURCE_MODE: mode_r     <= tpm_mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // Handshake: the sample register moves on whenever the result register
  // is empty or its result is being transferred.
  logic        smp_valid_r;
  tpm_sample_t smp_r;
  logic        out_valid_r;
  logic        res_load;
  logic        in_take;

  assign res_load = smp_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = smp_valid_r && !res_load;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
    end else if (in_take) begin
      smp_valid_r <= 1'b1;
    end else if (res_load) begin
      smp_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      smp_r <= '{down: in_raw_down, x: in_raw_x, y: in_raw_y, pressure: in_raw_pressure};
    end
  end

  // Calibrated resistive path.
  logic [DIM_W-1:0] aff_lx, aff_ly;

  tpm_affine #(
    .FRAC_BITS(FRAC_BITS),
    .LIMIT    (SCREEN_W - 1),
    .DIM_W    (DIM_W)
  ) u_aff_x (
    .coef_a(coef_ax_r),
    .coef_b(coef_bx_r),
    .coef_c(coef_cx_r),
    .raw_x (smp_r.x),
    .raw_y (smp_r.y),
    .coord (aff_lx)
  );

  tpm_affine #(
    .FRAC_BITS(FRAC_BITS),
    .LIMIT    (SCREEN_H - 1),
    .DIM_W    (DIM_W)
  ) u_aff_y (
    .coef_a(coef_ay_r),
    .coef_b(coef_by_r),
    .coef_c(coef_cy_r),
    .raw_x (smp_r.x),
    .raw_y (smp_r.y),
    .coord (aff_ly)
  );

  // Capacitive path: a quarter-turn out of native portrait, then the clamp.
  logic signed [CAP_W-1:0] cap_ly_raw;
  logic [DIM_W-1:0]        cap_lx, cap_ly;

  assign cap_ly_raw = $signed(CAP_W'(NATIVE_W - 1)) - $signed({2'b00, smp_r.x});

  always_comb begin
    if ({1'b0, smp_r.y} > (RAW_W + 1)'(SCREEN_W - 1)) begin
      cap_lx = DIM_W'(SCREEN_W - 1);
    end else begin
      cap_lx = smp_r.y[DIM_W-1:0];
    end
    if (cap_ly_raw[CAP_W-1]) begin
      cap_ly = '0;
    end else if (cap_ly_raw > $signed(CAP_W'(SCREEN_H - 1))) begin
      cap_ly = DIM_W'(SCREEN_H - 1);
    end else begin
      cap_ly = cap_ly_raw[DIM_W-1:0];
    end
  end

  logic             pressed_nxt;
  logic [DIM_W-1:0] land_x, land_y;
  logic [POS_W-1:0] rot_x, rot_y;

  always_comb begin
    case (mode_r)
      MODE_RES_CAL: begin
        pressed_nxt = smp_r.down;
        land_x      = aff_lx;
        land_y      = aff_ly;
      end
      MODE_CAP: begin
        pressed_nxt = smp_r.down;
        land_x      = cap_lx;
        land_y      = cap_ly;
      end
      default: begin
        pressed_nxt = 1'b0;
        land_x      = cap_lx;
        land_y      = cap_ly;
      end
    endcase
  end

  tpm_orient #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H),
    .DIM_W   (DIM_W)
  ) u_orient (
    .lx      (land_x),
    .ly      (land_y),
    .rotation(rotation_r),
    .pos_x   (rot_x),
    .pos_y   (rot_y)
  );

  // Press state and the point that is held while released.
  logic             last_pressed_r;
  logic [POS_W-1:0] last_pos_x_r, last_pos_y_r;
  logic [POS_W-1:0] pos_x_nxt, pos_y_nxt;

  assign pos_x_nxt = pressed_nxt ? rot_x : last_pos_x_r;
  assign pos_y_nxt = pressed_nxt ? rot_y : last_pos_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pressed_r <= 1'b0;
      last_pos_x_r   <= '0;
      last_pos_y_r   <= '0;
    end else if (res_load) begin
      last_pressed_r <= pressed_nxt;
      last_pos_x_r   <= pos_x_nxt;
      last_pos_y_r   <= pos_y_nxt;
    end
  end

  // Result register.
  logic              pressed_r, just_pressed_r, just_released_r;
  logic [POS_W-1:0]  pos_x_r, pos_y_r;
  logic [PRES_W-1:0] pressure_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      pressed_r       <= pressed_nxt;
      pos_x_r         <= pos_x_nxt;
      pos_y_r         <= pos_y_nxt;
      pressure_r      <= smp_r.pressure;
      just_pressed_r  <= pressed_nxt && !last_pressed_r;
      just_released_r <= !pressed_nxt && last_pressed_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pressed       = pressed_r;
  assign out_pos_x         = pos_x_r;
  assign out_pos_y         = pos_y_r;
  assign out_pressure_out  = pressure_r;
  assign out_just_pressed  = just_pressed_r;
  assign out_just_released = just_released_r;

endmodule

[hw/rtl/tpm_checker.sv]
// Port-level checker of the touch point mapper and its bind to the top level.
`timescale 1ns / 1ps
`include "touch_point_mapper_core_assert.svh"

module tpm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_pressed,
  input logic [tpm_pkg::POS_W-1:0]  out_pos_x,
  input logic [tpm_pkg::POS_W-1:0]  out_pos_y,
  input logic                       out_just_pressed,
  input logic                       out_just_released
);
  import tpm_pkg::*;

  // A press edge can only be flagged on a pressed result, a release edge
  // only on a released one.
  `TPM_ASSERT_NOW(a_jp_pressed, out_valid && out_just_pressed, out_pressed, "just_pressed without press")
  `TPM_ASSERT_NOW(a_jr_released, out_valid && out_just_released, !out_pressed, "just_released while pressed")

  // The input side is only held back when a result waits on a stalled receiver.
  `TPM_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without backpressure")

  // A stalled result keeps its point.
  `TPM_ASSERT_NEXT(a_hold_pos, out_valid && out_stall, out_valid && $stable(out_pos_x) && $stable(out_pos_y), "stalled result changed")

  // Reset leaves both sides empty and open.
  `TPM_ASSERT_ALWAYS_NEXT(a_reset_empty, !rst_n, !out_valid && !in_stall, "not empty after reset")

endmodule

bind touch_point_mapper_core tpm_checker u_tpm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pressed      (out_pressed),
  .out_pos_x        (out_pos_x),
  .out_pos_y        (out_pos_y),
  .out_just_pressed (out_just_pressed),
  .out_just_released(out_just_released)
);

[tb/tb.sv]
// Self-checking testbench for the touch point mapper core.
`timescale 1ns / 1ps

module tb;
  import tpm_pkg::*;

  localparam int SCR_W = 320;
  localparam int SCR_H = 240;
  localparam int NAT_W = 240;
  localparam int FRAC = 16;
  localparam int DRAIN = 4;
  localparam int PHASES = 11;
  localparam int PHASE_LEN = 150;
  localparam int unsigned GAIN_SPAN = 12000;
  localparam int unsigned OFFSET_SPAN = 400 * 65536;

  typedef struct {
    bit                pressed;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [PRES_W-1:0] pres;
    bit                jp;
    bit                jr;
  } touch_result_t;

  typedef struct {
    bit                is_cfg;
    tpm_reg_idx_t      idx;
    logic [COEF_W-1:0] data;
    tpm_sample_t       smp;
    bit                known;
    touch_result_t     res;
  } drill_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic in_raw_down;
  logic [RAW_W-1:0] in_raw_x;
  logic [RAW_W-1:0] in_raw_y;
  logic [PRES_W-1:0] in_raw_pressure;
  logic out_valid;
  logic out_stall;
  logic out_pressed;
  logic [POS_W-1:0] out_pos_x;
  logic [POS_W-1:0] out_pos_y;
  logic [PRES_W-1:0] out_pressure_out;
  logic out_just_pressed;
  logic out_just_released;

  touch_point_mapper_core #(
    .SCREEN_W (SCR_W),
    .SCREEN_H (SCR_H),
    .NATIVE_W (NAT_W),
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_raw_down      (in_raw_down),
    .in_raw_x         (in_raw_x),
    .in_raw_y         (in_raw_y),
    .in_raw_pressure  (in_raw_pressure),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pressed      (out_pressed),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_pressure_out (out_pressure_out),
    .out_just_pressed (out_just_pressed),
    .out_just_released(out_just_released)
  );

  // Mirror of the block's configuration and press state.
  longint coef [0:5];
  tpm_rot_t disp_rot;
  tpm_mode_t src_mode;
  bit was_pressed;
  logic [POS_W-1:0] held_x;
  logic [POS_W-1:0] held_y;

  touch_result_t pending_pts[$];
  touch_result_t due;
  drill_row_t drill[$];
  int errors;
  int samples_sent;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint round_q(longint v);
    longint half;
    half = longint'(1) << (FRAC - 1);
    if (v >= 0) return (v + half) >>> FRAC;
    return -((-v + half) >>> FRAC);
  endfunction

  function automatic longint clamp_to(longint v, longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Maps one sample to its screen result and advances the press state.
  function automatic touch_result_t map_touch(tpm_sample_t s);
    touch_result_t r;
    longint lx, ly, px, py, rx, ry;
    bit hit;
    lx = 0;
    ly = 0;
    px = 0;
    py = 0;
    hit = 1'b0;
    rx = longint'(s.x);
    ry = longint'(s.y);
    if (s.down && src_mode == MODE_RES_CAL) begin
      lx = round_q(coef[REG_COEF_AX] * rx + coef[REG_COEF_BX] * ry + coef[REG_COEF_CX]);
      ly = round_q(coef[REG_COEF_AY] * rx + coef[REG_COEF_BY] * ry + coef[REG_COEF_CY]);
      hit = 1'b1;
    end else if (s.down && src_mode == MODE_CAP) begin
      lx = ry;
      ly = NAT_W - 1 - rx;
      hit = 1'b1;
    end
    if (hit) begin
      lx = clamp_to(lx, SCR_W - 1);
      ly = clamp_to(ly, SCR_H - 1);
      case (disp_rot)
        ROT_QUARTER: begin
          px = SCR_H - 1 - ly;
          py = lx;
        end
        ROT_THREE_Q: begin
          px = ly;
          py = SCR_W - 1 - lx;
        end
        ROT_HALF: begin
          px = SCR_W - 1 - lx;
          py = SCR_H - 1 - ly;
        end
        default: begin
          px = lx;
          py = ly;
        end
      endcase
      r.pos_x = px[POS_W-1:0];
      r.pos_y = py[POS_W-1:0];
    end else begin
      r.pos_x = held_x;
      r.pos_y = held_y;
    end
    r.pressed = hit;
    r.pres = s.pressure;
    r.jp = hit && !was_pressed;
    r.jr = !hit && was_pressed;
    was_pressed = hit;
    held_x = r.pos_x;
    held_y = r.pos_y;
    return r;
  endfunction

  function automatic int draw_gap();
    if (calm) return 0;
    return $urandom_range(0, 1) ? $urandom_range(0, 18) : 0;
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef(int unsigned span);
    logic [COEF_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = $urandom;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'h8000_0000;
      3: v = '0;
      default: begin
        v = $urandom_range(0, span);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic check_field(string what, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pts.size() == 0) begin
        $display("%0t: result transfer with none expected, actual x %0d y %0d", $time,
                 out_pos_x, out_pos_y);
        errors++;
      end else begin
        due = pending_pts.pop_front();
        check_field("pressed", due.pressed, out_pressed);
        check_field("pos_x", due.pos_x, out_pos_x);
        check_field("pos_y", due.pos_y, out_pos_y);
        check_field("pressure_out", due.pres, out_pressure_out);
        check_field("just_pressed", due.jp, out_just_pressed);
        check_field("just_released", due.jr, out_just_released);
      end
    end
  end

  // Result side: stall for a drawn number of cycles before each transfer.
  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      n = draw_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  // Lowers cfg_we after each write and waits before returning, so cfg_we is never lowered and raised in one step.
  task automatic write_reg(tpm_reg_idx_t idx, logic [COEF_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROTATION:    disp_rot = tpm_rot_t'(d[1:0]);
      REG_SOURCE_MODE: src_mode = tpm_mode_t'(d[1:0]);
      default:         coef[idx] = longint'(signed'(d));
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Offers one sample and returns at the edge of its transfer.
  task automatic send(tpm_sample_t s, bit known, touch_result_t res);
    int gap;
    touch_result_t r;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_down <= s.down;
    in_raw_x <= s.x;
    in_raw_y <= s.y;
    in_raw_pressure <= s.pressure;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = map_touch(s);
    pending_pts.push_back(known ? res : r);
    samples_sent++;
  endtask

  function automatic void add_cfg(tpm_reg_idx_t idx, logic [COEF_W-1:0] d);
    drill_row_t row;
    row = '{idx: REG_COEF_AX, default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = d;
    drill.push_back(row);
  endfunction

  function automatic void add_sample(bit dn, int x, int y, int p, bit known, bit pr,
                                     int px, int py, bit jp, bit jr);
    drill_row_t row;
    row = '{idx: REG_COEF_AX, default: '0};
    row.smp.down = dn;
    row.smp.x = x[RAW_W-1:0];
    row.smp.y = y[RAW_W-1:0];
    row.smp.pressure = p[PRES_W-1:0];
    row.known = known;
    row.res.pressed = pr;
    row.res.pos_x = px[POS_W-1:0];
    row.res.pos_y = py[POS_W-1:0];
    row.res.pres = p[PRES_W-1:0];
    row.res.jp = jp;
    row.res.jr = jr;
    drill.push_back(row);
  endfunction

  initial begin
    tpm_sample_t s;
    touch_result_t none;
    logic [RAW_W-1:0] bx, by;
    int r, k, n;
    none = '{default: '0};
    errors = 0;
    samples_sent = 0;
    calm = 1'b0;
    for (int i = 0; i < 6; i++) coef[i] = 0;
    disp_rot = ROT_IDENTITY;
    src_mode = MODE_RES_UNCAL;
    was_pressed = 1'b0;
    held_x = '0;
    held_y = '0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_raw_down = 1'b0;
    in_raw_x = '0;
    in_raw_y = '0;
    in_raw_pressure = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Uncalibrated resistive after reset never reports a press.
    add_sample(1, 4095, 4095, 16'hFFFF, 1, 0, 0, 0, 0, 0);
    add_sample(0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    // Capacitive quarter-turn, corners clamp onto the screen edges.
    add_cfg(REG_SOURCE_MODE, 32'(MODE_CAP));
    add_sample(1, 0, 0, 16'h1234, 1, 1, 0, 239, 1, 0);
    add_sample(1, 4095, 4095, 16'h5555, 1, 1, 319, 0, 0, 0);
    add_sample(0, 4095, 0, 16'hAAAA, 1, 0, 319, 0, 0, 1);
    add_sample(0, 0, 4095, 16'h0001, 1, 0, 319, 0, 0, 0);
    add_cfg(REG_ROTATION, 32'(ROT_QUARTER));
    add_sample(1, 0, 0, 16'h8000, 1, 1, 0, 0, 1, 0);
    add_cfg(REG_ROTATION, 32'(ROT_THREE_Q));
    add_sample(1, 0, 0, 16'h7FFF, 1, 1, 239, 319, 0, 0);
    add_cfg(REG_ROTATION, 32'(ROT_HALF));
    add_sample(1, 0, 0, 16'h00FF, 1, 1, 319, 0, 0, 0);
    // The spare mode code behaves as uncalibrated and holds the last point.
    add_cfg(REG_SOURCE_MODE, 32'(MODE_UNUSED));
    add_sample(1, 100, 100, 16'hFF00, 1, 0, 319, 0, 0, 1);
    // Calibrated identity map, then offsets of plus and minus one half.
    add_cfg(REG_SOURCE_MODE, 32'(MODE_RES_CAL));
    add_cfg(REG_ROTATION, 32'(ROT_IDENTITY));
    add_cfg(REG_COEF_AX, 32'h0001_0000);
    add_cfg(REG_COEF_BX, 32'h0);
    add_cfg(REG_COEF_CX, 32'h0);
    add_cfg(REG_COEF_AY, 32'h0);
    add_cfg(REG_COEF_BY, 32'h0001_0000);
    add_cfg(REG_COEF_CY, 32'h0);
    add_sample(1, 100, 50, 16'h0F0F, 1, 1, 100, 50, 1, 0);
    add_sample(1, 4095, 4095, 16'hF0F0, 1, 1, 319, 239, 0, 0);
    add_cfg(REG_COEF_CX, 32'h0000_8000);
    add_sample(1, 10, 20, 16'h3333, 1, 1, 11, 20, 0, 0);
    add_cfg(REG_COEF_CX, 32'hFFFF_8000);
    add_sample(1, 10, 20, 16'hCCCC, 1, 1, 10, 20, 0, 0);
    // Extreme coefficients: the wide sum must not wrap before the clamp.
    add_cfg(REG_COEF_AX, 32'h7FFF_FFFF);
    add_cfg(REG_COEF_BX, 32'h7FFF_FFFF);
    add_cfg(REG_COEF_CX, 32'h7FFF_FFFF);
    add_cfg(REG_COEF_AY, 32'h8000_0000);
    add_cfg(REG_COEF_BY, 32'h8000_0000);
    add_cfg(REG_COEF_CY, 32'h8000_0000);
    add_sample(1, 4095, 4095, 16'hFFFF, 1, 1, 319, 0, 0, 0);
    add_sample(1, 0, 0, 16'h0000, 1, 1, 319, 0, 0, 0);
    add_sample(0, 0, 0, 16'h1111, 1, 0, 319, 0, 0, 1);
    // A plausible calibration under a quarter-turn, left to the predictor.
    add_cfg(REG_COEF_AX, 32'h0000_1400);
    add_cfg(REG_COEF_BX, 32'hFFFF_FF00);
    add_cfg(REG_COEF_CX, 32'h0008_4000);
    add_cfg(REG_COEF_AY, 32'h0000_0200);
    add_cfg(REG_COEF_BY, 32'h0000_0F00);
    add_cfg(REG_COEF_CY, 32'hFFF8_0000);
    add_cfg(REG_ROTATION, 32'(ROT_QUARTER));
    add_sample(1, 2048, 2048, 16'h2468, 0, 0, 0, 0, 0, 0);
    add_sample(1, 1, 4094, 16'hFEDC, 0, 0, 0, 0, 0, 0);
    add_sample(0, 4094, 1, 16'h0123, 0, 0, 0, 0, 0, 0);

    foreach (drill[i]) begin
      if (drill[i].is_cfg) begin
        wait_idle();
        write_reg(drill[i].idx, drill[i].data);
      end else begin
        send(drill[i].smp, drill[i].known, drill[i].res);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      r = $urandom_range(0, 99);
      for (int i = 0; i < 6; i++)
        write_reg(tpm_reg_idx_t'(i),
                  rand_coef((i == REG_COEF_CX || i == REG_COEF_CY) ? OFFSET_SPAN : GAIN_SPAN));
      write_reg(REG_ROTATION, 32'($urandom_range(0, 3)));
      write_reg(REG_SOURCE_MODE, r < 50 ? 32'(MODE_RES_CAL) : r < 85 ? 32'(MODE_CAP) :
                                 r < 93 ? 32'(MODE_RES_UNCAL) : 32'(MODE_UNUSED));
      calm = (ph % 3 == 2);
      while (samples_sent < drill.size() + PHASE_LEN * (ph + 1)) begin
        if ($urandom_range(0, 9) == 0) begin
          s.down = 1'($urandom_range(0, 1));
          s.x = RAW_W'($urandom);
          s.y = RAW_W'($urandom);
          s.pressure = PRES_W'($urandom);
          send(s, 1'b0, none);
        end else begin
          // A stroke: a run of contacts drifting around one spot, then a release.
          bx = $urandom_range(0, 1) ? RAW_W'($urandom_range(0, 4095)) :
                                      RAW_W'($urandom_range(0, 340));
          by = $urandom_range(0, 1) ? RAW_W'($urandom_range(0, 4095)) :
                                      RAW_W'($urandom_range(0, 340));
          n = $urandom_range(1, 12);
          for (k = 0; k < n; k++) begin
            s.down = 1'b1;
            s.x = bx;
            s.y = by;
            s.pressure = PRES_W'($urandom);
            send(s, 1'b0, none);
            bx = bx + RAW_W'($urandom_range(0, 16)) - RAW_W'(8);
            by = by + RAW_W'($urandom_range(0, 16)) - RAW_W'(8);
          end
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++) begin
            s.down = 1'b0;
            s.x = RAW_W'($urandom);
            s.y = RAW_W'($urandom);
            s.pressure = PRES_W'($urandom);
            send(s, 1'b0, none);
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (DRAIN * 2) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/tpm_pkg.sv
hw/rtl/tpm_affine.sv
hw/rtl/tpm_orient.sv
hw/rtl/touch_point_mapper_core.sv
hw/rtl/tpm_checker.sv
tb/tb.sv
